// ===== sv/ipid_pkg.sv =====
package ipid_pkg;

   localparam int GainFracBitsDefault = 8;

   localparam int ErrWidth    = 16;
   localparam int GainWidth   = 16;
   localparam int LimitWidth  = 15;
   localparam int D1Width     = ErrWidth + 1;
   localparam int D2Width     = ErrWidth + 2;
   localparam int ProdWidth   = GainWidth + D2Width;
   localparam int CsrIdxWidth = 3;

   typedef enum logic [CsrIdxWidth-1:0] {
      CSR_GAIN_P,
      CSR_GAIN_I,
      CSR_GAIN_D,
      CSR_MOTOR_LIMIT,
      CSR_OUTPUT_LIMIT
   } csr_index_type;

   typedef struct packed {
      logic signed [ProdWidth-1:0] prod_p;
      logic signed [ProdWidth-1:0] prod_i;
      logic signed [ProdWidth-1:0] prod_d;
   } prod_type;

   // Divide by 2^frac truncating toward zero, then clamp to +-limit.
   function automatic logic signed [ErrWidth-1:0] scale_clamp(
      input logic signed [ProdWidth-1:0]  prod,
      input logic        [LimitWidth-1:0] limit,
      input int unsigned                  frac
   );
      logic signed [ProdWidth-1:0] bias;
      logic signed [ProdWidth-1:0] q;
      logic signed [ProdWidth-1:0] hi;
      logic signed [ProdWidth-1:0] lo;
      bias = prod[ProdWidth-1] ? ((ProdWidth'(1) << frac) - ProdWidth'(1)) : '0;
      q    = (prod + bias) >>> frac;
      hi   = {{(ProdWidth-LimitWidth){1'b0}}, limit};
      lo   = -hi;
      if (q > hi) begin
         return hi[ErrWidth-1:0];
      end else if (q < lo) begin
         return lo[ErrWidth-1:0];
      end else begin
         return q[ErrWidth-1:0];
      end
   endfunction

endpackage

// ===== sv/incremental_pid_controller.sv =====
// Velocity-form PID controller. Each error sample taken on req_ yields one
// drive value on rsp_: the P, I and D increments (Q8.8 gains on the first
// difference, the error and the second difference, truncated toward zero and
// each clamped to +-motor_limit) are added to a running output that is then
// clamped to the smaller of motor_limit and output_limit. A new sample can be
// taken every cycle while the result side is not stalled by rsp_ready; each
// sample passes through the difference register, then the product register,
// then the accumulator/result register, and the accumulator loop closed in the
// last stage sets that rate.
// The user must write gains and limits through csr_ only while no transaction
// is in flight (not enforced by the block); writes to unused indexes are ignored.
module incremental_pid_controller
   import ipid_pkg::*;
#(
   parameter int GainFracBits = GainFracBitsDefault
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [ErrWidth-1:0]   req_error_sample,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [ErrWidth-1:0]   rsp_drive_value,
   input  logic                         csr_write,
   input  logic        [CsrIdxWidth-1:0] csr_index,
   input  logic        [GainWidth-1:0]  csr_data
);

   logic signed [GainWidth-1:0]  gain_p_ff;
   logic signed [GainWidth-1:0]  gain_i_ff;
   logic signed [GainWidth-1:0]  gain_d_ff;
   logic        [LimitWidth-1:0] motor_limit_ff;
   logic        [LimitWidth-1:0] output_limit_ff;
   logic                         prod_valid;
   logic                         prod_ready;
   prod_type                     prod;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff       <= '0;
         gain_i_ff       <= '0;
         gain_d_ff       <= '0;
         motor_limit_ff  <= '1;
         output_limit_ff <= '1;
      end else if (csr_write) begin
         unique case (csr_index_type'(csr_index))
            CSR_GAIN_P:       gain_p_ff       <= csr_data;
            CSR_GAIN_I:       gain_i_ff       <= csr_data;
            CSR_GAIN_D:       gain_d_ff       <= csr_data;
            CSR_MOTOR_LIMIT:  motor_limit_ff  <= csr_data[LimitWidth-1:0];
            CSR_OUTPUT_LIMIT: output_limit_ff <= csr_data[LimitWidth-1:0];
            default: ;
         endcase
      end
   end

   ipid_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .gain_p           (gain_p_ff),
      .gain_i           (gain_i_ff),
      .gain_d           (gain_d_ff),
      .prod_valid       (prod_valid),
      .prod_ready       (prod_ready),
      .prod             (prod)
   );

   ipid_back #(
      .GainFracBits (GainFracBits)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .prod_valid      (prod_valid),
      .prod_ready      (prod_ready),
      .prod            (prod),
      .motor_limit     (motor_limit_ff),
      .output_limit    (output_limit_ff),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_drive_value (rsp_drive_value)
   );

endmodule

// ===== sv/ipid_front.sv =====
module ipid_front
   import ipid_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic signed [ErrWidth-1:0]  req_error_sample,
   input  logic signed [GainWidth-1:0] gain_p,
   input  logic signed [GainWidth-1:0] gain_i,
   input  logic signed [GainWidth-1:0] gain_d,
   output logic                        prod_valid,
   input  logic                        prod_ready,
   output prod_type                    prod
);

   logic                       s1_valid_ff;
   logic signed [ErrWidth-1:0] err_ff, err_in;
   logic signed [D1Width-1:0]  d1_ff, d1_in;
   logic signed [D2Width-1:0]  d2_ff, d2_in;
   logic signed [ErrWidth-1:0] prev_err_ff;
   logic signed [ErrWidth-1:0] prev2_err_ff;
   logic                       s2_valid_ff;
   prod_type                   prod_ff, prod_in;
   logic                       s1_take;
   logic                       s2_take;
   logic                       req_fire;

   assign s2_take   = !s2_valid_ff || prod_ready;
   assign s1_take   = !s1_valid_ff || s2_take;
   assign req_ready = s1_take;
   assign req_fire  = req_valid && s1_take;

   // first and second differences against the error history
   always_comb begin
      err_in = req_error_sample;
      d1_in  = D1Width'(req_error_sample) - D1Width'(prev_err_ff);
      d2_in  = D2Width'(req_error_sample) - (D2Width'(prev_err_ff) <<< 1)
             + D2Width'(prev2_err_ff);
   end

   always_comb begin
      prod_in.prod_p = {{(ProdWidth-GainWidth){gain_p[GainWidth-1]}}, gain_p}
                     * {{(ProdWidth-D1Width){d1_ff[D1Width-1]}}, d1_ff};
      prod_in.prod_i = {{(ProdWidth-GainWidth){gain_i[GainWidth-1]}}, gain_i}
                     * {{(ProdWidth-ErrWidth){err_ff[ErrWidth-1]}}, err_ff};
      prod_in.prod_d = {{(ProdWidth-GainWidth){gain_d[GainWidth-1]}}, gain_d}
                     * {{(ProdWidth-D2Width){d2_ff[D2Width-1]}}, d2_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         prev_err_ff  <= '0;
         prev2_err_ff <= '0;
      end else begin
         if (s1_take) begin
            s1_valid_ff <= req_valid;
         end
         if (s2_take) begin
            s2_valid_ff <= s1_valid_ff;
         end
         if (req_fire) begin
            prev_err_ff  <= req_error_sample;
            prev2_err_ff <= prev_err_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         err_ff <= err_in;
         d1_ff  <= d1_in;
         d2_ff  <= d2_in;
      end
      if (s2_take && s1_valid_ff) begin
         prod_ff <= prod_in;
      end
   end

   assign prod_valid = s2_valid_ff;
   assign prod       = prod_ff;

   a_history_shift : assert property (@(posedge clock) disable iff (reset)
      req_fire |=> (prev_err_ff == $past(req_error_sample))
                   && (prev2_err_ff == $past(prev_err_ff)))
      else $error("error history did not shift on accepted transaction");

   a_prod_held : assert property (@(posedge clock) disable iff (reset)
      prod_valid && !prod_ready |=> prod_valid && $stable(prod_ff))
      else $error("stalled product stage lost its contents");

   a_stage1_kept : assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !s2_take |=> s1_valid_ff && $stable(d2_ff))
      else $error("difference stage overwritten while stalled");

endmodule

// ===== sv/ipid_back.sv =====
module ipid_back
   import ipid_pkg::*;
#(
   parameter int GainFracBits = GainFracBitsDefault
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        prod_valid,
   output logic                        prod_ready,
   input  prod_type                    prod,
   input  logic        [LimitWidth-1:0] motor_limit,
   input  logic        [LimitWidth-1:0] output_limit,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic signed [ErrWidth-1:0]  rsp_drive_value
);

   localparam int SumWidth = ErrWidth + 2;

   logic                       rsp_valid_ff;
   logic signed [ErrWidth-1:0] acc_ff, acc_in;
   logic signed [ErrWidth-1:0] term_p, term_i, term_d;
   logic signed [SumWidth-1:0] sum;
   logic signed [SumWidth-1:0] hi, lo;
   logic        [LimitWidth-1:0] lim_eff;
   logic                       fire;

   assign prod_ready = !rsp_valid_ff || rsp_ready;
   assign fire       = prod_valid && prod_ready;

   always_comb begin
      term_p  = scale_clamp(prod.prod_p, motor_limit, GainFracBits);
      term_i  = scale_clamp(prod.prod_i, motor_limit, GainFracBits);
      term_d  = scale_clamp(prod.prod_d, motor_limit, GainFracBits);
      sum     = SumWidth'(acc_ff) + SumWidth'(term_p) + SumWidth'(term_i)
              + SumWidth'(term_d);
      // two symmetric clamps in a row reduce to the tighter one
      lim_eff = (motor_limit < output_limit) ? motor_limit : output_limit;
      hi      = {{(SumWidth-LimitWidth){1'b0}}, lim_eff};
      lo      = -hi;
      if (sum > hi) begin
         acc_in = hi[ErrWidth-1:0];
      end else if (sum < lo) begin
         acc_in = lo[ErrWidth-1:0];
      end else begin
         acc_in = sum[ErrWidth-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         acc_ff       <= '0;
      end else begin
         if (fire) begin
            rsp_valid_ff <= 1'b1;
            acc_ff       <= acc_in;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_drive_value = acc_ff;

   a_drive_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_drive_value != {1'b1, {(ErrWidth-1){1'b0}}})
      else $error("drive value outside symmetric range");

   a_fire_to_rsp : assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_valid && (acc_ff == $past(acc_in)))
      else $error("result register not loaded on product transaction");

   a_acc_hold : assert property (@(posedge clock) disable iff (reset)
      !fire |=> $stable(acc_ff))
      else $error("accumulator changed without a transaction");

endmodule

// ===== dv/ipid_drive_checker.sv =====
`timescale 1ns / 100ps

module ipid_drive_checker
   import ipid_pkg::*;
(
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   input  logic                          req_ready,
   input  logic signed [ErrWidth-1:0]    req_error_sample,
   input  logic                          rsp_valid,
   input  logic                          rsp_ready,
   input  logic signed [ErrWidth-1:0]    rsp_drive_value,
   input  logic                          csr_write,
   input  logic        [CsrIdxWidth-1:0] csr_index,
   input  logic        [GainWidth-1:0]   csr_data,
   output int                            mismatch_count,
   output int                            drives_pending
);

   logic signed [GainWidth-1:0]  gain_p;
   logic signed [GainWidth-1:0]  gain_i;
   logic signed [GainWidth-1:0]  gain_d;
   logic        [LimitWidth-1:0] motor_limit;
   logic        [LimitWidth-1:0] output_limit;

   longint err_prev;
   longint err_prev2;
   longint drive_acc;

   logic signed [ErrWidth-1:0] expected_drive[$];
   int mismatches;

   function automatic longint limit_to(input longint x, input longint lim);
      if (x > lim) begin
         x = lim;
      end
      if (x < -lim) begin
         x = -lim;
      end
      return x;
   endfunction

   // Full-width product, divided with truncation toward zero, then clamped.
   function automatic longint gained_term(input longint gain, input longint diff,
                                          input longint lim);
      return limit_to((gain * diff) / (longint'(1) << GainFracBitsDefault), lim);
   endfunction

   task automatic report_mismatch(input string msg);
      $display("ERROR %0t: %s", $time, msg);
      mismatches++;
   endtask

   always @(posedge clock) begin : track
      longint                     sample;
      longint                     term_p;
      longint                     term_i;
      longint                     term_d;
      longint                     acc;
      logic signed [ErrWidth-1:0] want;
      if (reset) begin
         gain_p       = '0;
         gain_i       = '0;
         gain_d       = '0;
         motor_limit  = '1;
         output_limit = '1;
         err_prev     = 0;
         err_prev2    = 0;
         drive_acc    = 0;
         expected_drive.delete();
      end else begin
         if (csr_write) begin
            case (csr_index)
               CSR_GAIN_P:       gain_p       = csr_data;
               CSR_GAIN_I:       gain_i       = csr_data;
               CSR_GAIN_D:       gain_d       = csr_data;
               CSR_MOTOR_LIMIT:  motor_limit  = csr_data[LimitWidth-1:0];
               CSR_OUTPUT_LIMIT: output_limit = csr_data[LimitWidth-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            sample = req_error_sample;
            term_p = gained_term(gain_p, sample - err_prev, motor_limit);
            term_i = gained_term(gain_i, sample, motor_limit);
            term_d = gained_term(gain_d, sample - 2 * err_prev + err_prev2, motor_limit);
            acc = drive_acc + term_p + term_i + term_d;
            acc = limit_to(limit_to(acc, motor_limit), output_limit);
            drive_acc = acc;
            err_prev2 = err_prev;
            err_prev  = sample;
            expected_drive.push_back(ErrWidth'(acc));
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_drive.size() == 0) begin
               report_mismatch($sformatf("drive_value %0d with no transaction outstanding",
                                         rsp_drive_value));
            end else begin
               want = expected_drive.pop_front();
               if (rsp_drive_value !== want) begin
                  report_mismatch($sformatf("drive_value got %0d expected %0d",
                                            rsp_drive_value, want));
               end
            end
         end
      end
      drives_pending <= expected_drive.size();
      mismatch_count <= mismatches;
   end

endmodule

// ===== dv/tb_incremental_pid_controller.sv =====
`timescale 1ns / 100ps

module tb_incremental_pid_controller;
   import ipid_pkg::*;

   localparam int ClockHalf     = 4;
   localparam int ResetCycles   = 5;
   localparam int PhaseCount    = 6;
   localparam int PhaseItems    = 300;
   localparam int DrainCycles   = 16;
   localparam int WatchdogLimit = 2000;
   localparam int CsrIndexCount = 5;

   localparam logic signed [ErrWidth-1:0] ErrMax = {1'b0, {(ErrWidth-1){1'b1}}};
   localparam logic signed [ErrWidth-1:0] ErrMin = {1'b1, {(ErrWidth-1){1'b0}}};
   localparam logic [GainWidth-1:0] GainMax  = 16'h7FFF;
   localparam logic [GainWidth-1:0] GainMin  = 16'h8000;
   localparam logic [GainWidth-1:0] LimitMax = 16'h7FFF;

   logic                          clock;
   logic                          reset            = 1'b1;
   logic                          req_valid        = 1'b0;
   logic                          req_ready;
   logic signed [ErrWidth-1:0]    req_error_sample = '0;
   logic                          rsp_valid;
   logic                          rsp_ready        = 1'b0;
   logic signed [ErrWidth-1:0]    rsp_drive_value;
   logic                          csr_write        = 1'b0;
   logic        [CsrIdxWidth-1:0] csr_index        = '0;
   logic        [GainWidth-1:0]   csr_data         = '0;

   int mismatch_count;
   int drives_pending;
   int send_idle_pct = 26;
   int recv_idle_pct = 62;
   int quiet_cycles  = 0;
   logic signed [ErrWidth-1:0] last_sample = '0;

   incremental_pid_controller dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_value  (rsp_drive_value),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   ipid_drive_checker drive_monitor (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_error_sample (req_error_sample),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_drive_value  (rsp_drive_value),
      .csr_write        (csr_write),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .mismatch_count   (mismatch_count),
      .drives_pending   (drives_pending)
   );

   initial begin
      clock = 1'b0;
      forever #ClockHalf clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= WatchdogLimit) begin
         $display("tb_incremental_pid_controller failed");
         $finish;
      end
   end

   task automatic send_sample(input logic signed [ErrWidth-1:0] sample);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_error_sample <= sample;
      last_sample       = sample;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   // Drop valid and wait until every accepted transaction has been answered.
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (drives_pending != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CsrIdxWidth-1:0] index,
                            input logic [GainWidth-1:0]   value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_data  <= value;
      @(posedge clock);
   endtask

   task automatic write_settings(input logic [GainWidth-1:0] gp, input logic [GainWidth-1:0] gi,
                                 input logic [GainWidth-1:0] gd, input logic [GainWidth-1:0] ml,
                                 input logic [GainWidth-1:0] ol);
      write_reg(CSR_GAIN_P, gp);
      write_reg(CSR_GAIN_I, gi);
      write_reg(CSR_GAIN_D, gd);
      write_reg(CSR_MOTOR_LIMIT, ml);
      write_reg(CSR_OUTPUT_LIMIT, ol);
      // unused index, must not disturb anything
      write_reg(CsrIdxWidth'(CsrIndexCount +
                $urandom_range((1 << CsrIdxWidth) - 1 - CsrIndexCount)),
                GainWidth'($urandom));
      csr_write <= 1'b0;
   endtask

   function automatic logic [GainWidth-1:0] pick_gain();
      case ($urandom_range(7))
         0:       return GainMax;
         1:       return GainMin;
         2, 3:    return GainWidth'($urandom);
         default: return GainWidth'($urandom_range(1024) - 512);
      endcase
   endfunction

   function automatic logic [GainWidth-1:0] pick_limit();
      case ($urandom_range(9))
         0:       return '0;
         1:       return LimitMax;
         2, 3, 4: return GainWidth'($urandom_range(int'(LimitMax)));
         default: return GainWidth'($urandom_range(2000, 1));
      endcase
   endfunction

   function automatic logic signed [ErrWidth-1:0] pick_sample(
      input logic signed [ErrWidth-1:0] prev
   );
      int step;
      step = 0;
      case ($urandom_range(9))
         0, 1, 2, 3: return ErrWidth'($urandom);
         4, 5:       return ErrWidth'($urandom_range(512) - 256);
         6, 7: begin
            // slow ramp around the previous error
            step = int'(prev) + int'($urandom_range(64)) - 32;
            if (step > int'(ErrMax)) begin
               step = int'(ErrMax);
            end
            if (step < int'(ErrMin)) begin
               step = int'(ErrMin);
            end
            return ErrWidth'(step);
         end
         8: begin
            case ($urandom_range(3))
               0:       return ErrMax;
               1:       return ErrMin;
               2:       return '0;
               default: return '1;
            endcase
         end
         default: return prev;
      endcase
   endfunction

   initial begin
      repeat (ResetCycles) @(posedge clock);
      reset <= 1'b0;

      // reset gains are zero, so drive stays at zero
      send_sample(ErrMax);
      send_sample(ErrMin);
      settle();

      // full-scale swings: second difference reaches four times full scale
      write_settings(GainMax, GainMin, GainMax, LimitMax, LimitMax);
      send_sample(ErrMax);
      send_sample(ErrMin);
      send_sample(ErrMax);
      send_sample(ErrMin);
      send_sample('0);
      send_sample(ErrWidth'(-1));
      send_sample(ErrWidth'(1));
      settle();

      // fractional gains: negative products truncate toward zero; output limit below motor
      write_settings(16'h0180, 16'hFE80, 16'h0001, LimitMax, 16'd100);
      send_sample(ErrWidth'(-1));
      send_sample(ErrWidth'(1));
      send_sample(ErrWidth'(-3));
      send_sample(ErrWidth'(5));
      send_sample(ErrWidth'(-7));
      send_sample(ErrWidth'(200));
      settle();

      // zero motor limit, then zero output limit
      write_settings(GainMax, GainMax, GainMax, '0, LimitMax);
      send_sample(ErrWidth'(1000));
      send_sample(ErrWidth'(-1000));
      settle();
      write_settings(GainMax, GainMax, GainMax, LimitMax, '0);
      send_sample(ErrWidth'(5));
      send_sample(ErrWidth'(-5));

      for (int phase = 0; phase < PhaseCount; phase++) begin
         settle();
         case (phase / 2)
            0: begin
               send_idle_pct  = 26;
               recv_idle_pct <= 62;
            end
            1: begin
               send_idle_pct  = 62;
               recv_idle_pct <= 26;
            end
            default: begin
               send_idle_pct  = 0;
               recv_idle_pct <= 0;
            end
         endcase
         write_settings(pick_gain(), pick_gain(), pick_gain(), pick_limit(), pick_limit());
         repeat (PhaseItems) send_sample(pick_sample(last_sample));
      end

      settle();
      repeat (DrainCycles) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_incremental_pid_controller passed");
      end else begin
         $display("tb_incremental_pid_controller failed");
      end
      $finish;
   end

endmodule
